@@ design/sle_pkg.sv @@
// Package for the sequential list engine: field widths, operation and status
// codes, controller states and the command/status structs between the units.
// No dependencies; every other design file imports it.
`default_nettype none

package sle_pkg;

	// Default list capacity and fixed field widths.
	localparam int CAPACITY_DEF = 16;
	localparam int MODE_W       = 4;
	localparam int POS_W        = 5;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 5;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_BACK    = 4'd0,
		MODE_POP_BACK     = 4'd1,
		MODE_PUSH_FRONT   = 4'd2,
		MODE_POP_FRONT    = 4'd3,
		MODE_INSERT       = 4'd4,
		MODE_ERASE        = 4'd5,
		MODE_FIND         = 4'd6,
		MODE_REMOVE_FIRST = 4'd7,
		MODE_REMOVE_ALL   = 4'd8
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Kinds of memory walk the datapath performs.
	typedef enum logic [2:0] {
		WALK_UP,
		WALK_DROP_POS,
		WALK_DROP_FIRST,
		WALK_DROP_ALL,
		WALK_FIND
	} walk_t;

	// Where a walk starts.
	typedef enum logic [1:0] {
		START_ZERO,
		START_POS,
		START_CNT
	} start_t;

	// Entry count updates.
	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_LOAD_K
	} cnt_op_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_PUT,
		S_RD_FIRST,
		S_RD_LAST,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    in_ready;
		logic    walk_start;
		walk_t   walk_kind;
		start_t  start_sel;
		logic    walk_step;
		logic    put;
		cnt_op_t cnt_op;
		logic    set_status;
		status_t status;
		logic    rd_first;
		logic    rd_last;
		logic    out_load;
	} sle_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              in_fire;
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              empty;
		logic              pos_above_cnt;
		logic              pos_at_or_above_cnt;
		logic              walk_busy;
		logic              dropped;
		walk_t             walk_kind;
		logic              out_free;
	} sle_sts_t;

endpackage

`default_nettype wire

@@ design/sle_if.sv @@
// Valid/ready channel interfaces for list operations and their results.
// Depends on sle_pkg for the field widths.
`default_nettype none

interface sle_in_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, mode, position, value, input ready);
	modport sink   (input valid, mode, position, value, output ready);
endinterface

interface sle_out_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic                     found;
	logic [COUNT_W-1:0]       count;
	logic [COUNT_W-1:0]       free_slots;
	logic signed [DATA_W-1:0] first_value;
	logic signed [DATA_W-1:0] last_value;

	modport source (output valid, status, found, count, free_slots, first_value, last_value,
		input ready);
	modport sink   (input valid, status, found, count, free_slots, first_value, last_value,
		output ready);
endinterface

`default_nettype wire

@@ design/sle_ctrl.sv @@
// Controller state machine of the list engine: decodes the operation, sequences
// the memory walk, the final write and the readout. Depends on sle_pkg.
`default_nettype none

module sle_ctrl import sle_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire sle_sts_t sts,
	output sle_cmd_t      cmd
);

	state_t  state_q;
	state_t  state_d;

	status_t dec_status;
	logic    dec_walk;
	walk_t   dec_kind;
	start_t  dec_start;
	logic    dec_pop;

	// Decode the latched operation against the current list state.
	always_comb begin
		dec_status = ST_OK;
		dec_walk   = 1'b0;
		dec_kind   = WALK_UP;
		dec_start  = START_ZERO;
		dec_pop    = 1'b0;
		case (sts.mode)
			MODE_PUSH_BACK: begin
				if (sts.full) dec_status = ST_FULL;
				else begin
					dec_walk  = 1'b1;
					dec_start = START_CNT;
				end
			end
			MODE_POP_BACK: begin
				if (sts.empty) dec_status = ST_EMPTY;
				else dec_pop = 1'b1;
			end
			MODE_PUSH_FRONT: begin
				if (sts.full) dec_status = ST_FULL;
				else dec_walk = 1'b1;
			end
			MODE_POP_FRONT: begin
				if (sts.empty) dec_status = ST_EMPTY;
				else begin
					dec_walk = 1'b1;
					dec_kind = WALK_DROP_POS;
				end
			end
			MODE_INSERT: begin
				if (sts.full) dec_status = ST_FULL;
				else if (sts.pos_above_cnt) dec_status = ST_BADPOS;
				else begin
					dec_walk  = 1'b1;
					dec_start = START_POS;
				end
			end
			MODE_ERASE: begin
				if (sts.empty) dec_status = ST_EMPTY;
				else if (sts.pos_at_or_above_cnt) dec_status = ST_BADPOS;
				else begin
					dec_walk  = 1'b1;
					dec_kind  = WALK_DROP_POS;
					dec_start = START_POS;
				end
			end
			MODE_FIND: begin
				dec_walk = 1'b1;
				dec_kind = WALK_FIND;
			end
			MODE_REMOVE_FIRST: begin
				dec_walk = 1'b1;
				dec_kind = WALK_DROP_FIRST;
			end
			MODE_REMOVE_ALL: begin
				dec_walk = 1'b1;
				dec_kind = WALK_DROP_ALL;
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (sts.in_fire) state_d = S_DECIDE;
			S_DECIDE:   state_d = dec_walk ? S_WALK : S_RD_FIRST;
			S_WALK: begin
				if (!sts.walk_busy) begin
					state_d = (sts.walk_kind == WALK_UP) ? S_PUT : S_RD_FIRST;
				end
			end
			S_PUT:      state_d = S_RD_FIRST;
			S_RD_FIRST: state_d = S_RD_LAST;
			S_RD_LAST:  state_d = S_FINISH;
			S_FINISH:   if (sts.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			S_DECIDE: begin
				cmd.set_status = 1'b1;
				cmd.status     = dec_status;
				cmd.walk_start = dec_walk;
				cmd.walk_kind  = dec_kind;
				cmd.start_sel  = dec_start;
				cmd.cnt_op     = dec_pop ? CNT_DEC : CNT_HOLD;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (!sts.walk_busy && sts.walk_kind != WALK_UP) begin
					if (sts.walk_kind != WALK_FIND) cmd.cnt_op = CNT_LOAD_K;
					if (!sts.dropped) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NOTFOUND;
					end
				end
			end
			S_PUT: begin
				cmd.put    = 1'b1;
				cmd.cnt_op = CNT_INC;
			end
			S_RD_FIRST: begin
				cmd.rd_first = 1'b1;
			end
			S_RD_LAST: begin
				cmd.rd_last = 1'b1;
			end
			S_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

@@ design/sle_dpath.sv @@
// Datapath of the list engine: entry memory, entry count, walk counters and
// the result register. Depends on sle_pkg and the channel interfaces.
`default_nettype none

module sle_dpath import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sle_in_if.sink        req,
	sle_out_if.source     rsp,
	input  wire sle_cmd_t cmd,
	output sle_sts_t      sts
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int EXT_W = CNT_W + POS_W;

	// Entry memory.
	logic [DATA_W-1:0] mem [CAPACITY];

	// Latched operation.
	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] value_q;

	// Count and walk state.
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  start_q;
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  ridx_s1;
	logic              rv_s1;
	logic [DATA_W-1:0] rdata_s1;
	logic              dropped_q;
	walk_t             kind_q;
	status_t           status_q;
	logic [DATA_W-1:0] first_q;

	// Result register.
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      res_status_q;
	logic                     res_found_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic [COUNT_W-1:0]       res_free_q;
	logic [DATA_W-1:0]        res_first_q;
	logic [DATA_W-1:0]        res_last_q;

	logic              in_fire;
	logic [EXT_W-1:0]  pos_ext;
	logic [EXT_W-1:0]  cnt_ext;
	logic [EXT_W-1:0]  free_ext;
	logic [CNT_W-1:0]  start_val;
	logic [CNT_W-1:0]  cnt_m1;
	logic              issue;
	logic              proc;
	logic              match;
	logic              skip;
	logic              wen;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic              ren;
	logic [IDX_W-1:0]  raddr;
	logic              out_free;

	assign in_fire   = req.valid && cmd.in_ready;
	assign req.ready = cmd.in_ready;

	// Compare helpers in one common width, and the count minus one.
	assign pos_ext  = EXT_W'(pos_q);
	assign cnt_ext  = EXT_W'(cnt_q);
	assign free_ext = EXT_W'(CAPACITY) - cnt_ext;
	assign cnt_m1   = cnt_q - 1'b1;

	// Start index of a walk.
	always_comb begin
		case (cmd.start_sel)
			START_ZERO: start_val = '0;
			START_POS:  start_val = pos_ext[CNT_W-1:0];
			START_CNT:  start_val = cnt_q;
			default:    start_val = '0;
		endcase
	end

	// Walk read issue, and processing of the read data in the cycle after its issue.
	assign issue = cmd.walk_step && (rem_q != '0);
	assign proc  = cmd.walk_step && rv_s1;
	assign match = (rdata_s1 == value_q);

	always_comb begin
		case (kind_q)
			WALK_DROP_POS:   skip = !dropped_q;
			WALK_DROP_FIRST: skip = match && !dropped_q;
			WALK_DROP_ALL:   skip = match;
			WALK_FIND:       skip = match;
			default:         skip = 1'b0;
		endcase
	end

	// Memory write port: the walk moves entries, the put stores the new value.
	always_comb begin
		wen   = 1'b0;
		waddr = start_q[IDX_W-1:0];
		wdata = value_q;
		if (cmd.put) begin
			wen = 1'b1;
		end else if (proc) begin
			wdata = rdata_s1;
			if (kind_q == WALK_UP) begin
				wen   = 1'b1;
				waddr = IDX_W'(ridx_s1 + 1'b1);
			end else if (kind_q != WALK_FIND && !skip) begin
				wen   = 1'b1;
				waddr = k_q[IDX_W-1:0];
			end
		end
	end

	// Memory read port: walk reads, then the first and last entries.
	always_comb begin
		ren   = issue || cmd.rd_first || cmd.rd_last;
		raddr = rd_q[IDX_W-1:0];
		if (cmd.rd_first) raddr = '0;
		else if (cmd.rd_last) raddr = cnt_m1[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (ren) rdata_s1 <= mem[raddr];
	end

	// Control registers: count, remaining reads, read pipeline valid, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rem_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:    cnt_q <= cnt_q + 1'b1;
				CNT_DEC:    cnt_q <= cnt_q - 1'b1;
				CNT_LOAD_K: cnt_q <= k_q;
				default:    cnt_q <= cnt_q;
			endcase
			if (cmd.walk_start) rem_q <= cnt_q - start_val;
			else if (issue) rem_q <= rem_q - 1'b1;
			rv_s1 <= issue;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Operation latch, walk counters and status.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= req.mode;
			pos_q   <= req.position;
			value_q <= req.value;
		end
		if (cmd.walk_start) begin
			start_q   <= start_val;
			k_q       <= start_val;
			dropped_q <= 1'b0;
			kind_q    <= cmd.walk_kind;
			rd_q      <= (cmd.walk_kind == WALK_UP) ? cnt_m1 : start_val;
		end else begin
			if (issue) begin
				rd_q    <= (kind_q == WALK_UP) ? rd_q - 1'b1 : rd_q + 1'b1;
				ridx_s1 <= rd_q;
			end
			if (proc) begin
				if (skip) dropped_q <= 1'b1;
				else if (kind_q != WALK_UP && kind_q != WALK_FIND) k_q <= k_q + 1'b1;
			end
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.rd_last) first_q <= rdata_s1;
	end

	// Result register load.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status_q <= status_q;
			res_found_q  <= (mode_q == MODE_FIND) && dropped_q;
			res_count_q  <= cnt_ext[COUNT_W-1:0];
			res_free_q   <= free_ext[COUNT_W-1:0];
			res_first_q  <= (cnt_q == '0) ? '0 : first_q;
			res_last_q   <= (cnt_q == '0) ? '0 : rdata_s1;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = res_status_q;
	assign rsp.found       = res_found_q;
	assign rsp.count       = res_count_q;
	assign rsp.free_slots  = res_free_q;
	assign rsp.first_value = res_first_q;
	assign rsp.last_value  = res_last_q;

	// Status toward the controller.
	always_comb begin
		sts                     = '0;
		sts.in_fire             = in_fire;
		sts.mode                = mode_q;
		sts.full                = cnt_q >= CNT_W'(CAPACITY);
		sts.empty               = cnt_q == '0;
		sts.pos_above_cnt       = pos_ext > cnt_ext;
		sts.pos_at_or_above_cnt = pos_ext >= cnt_ext;
		sts.walk_busy           = (rem_q != '0) || rv_s1;
		sts.dropped             = dropped_q;
		sts.walk_kind           = kind_q;
		sts.out_free            = out_free;
	end

endmodule

`default_nettype wire

@@ design/sequential_list_engine_unit.sv @@
// Sequential list engine: an ordered list of up to CAPACITY signed 32-bit
// values held in a single-port-write, single-port-read memory. One operation
// is taken at a time; ready is high only while the engine is idle. An
// operation that reads entries of the memory (the shift for push front,
// insert, pop front and erase, or the scan for find and the two removes)
// walks them through the memory read port, one entry per cycle, and push
// front and insert then write the new value after the shift. Every operation
// ends by reading out the first and last entries. The next operation is
// taken while a finished result still waits in the output register; an
// operation that finishes while the earlier result is still waiting holds
// in its finish state until that result is taken. Entries need no clearing
// after reset.
// Depends on sle_pkg, sle_if, sle_ctrl and sle_dpath.
`default_nettype none

module sequential_list_engine_unit import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sle_in_if.sink    req,
	sle_out_if.source rsp
);

	sle_cmd_t cmd;
	sle_sts_t sts;

	// Sequencer.
	sle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Storage and result path.
	sle_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire

@@ design/sle_checker.sv @@
// Port-level checker for the list engine and its bind to the top level.
// Depends on sle_pkg.
`default_nettype none

module sle_checker import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic                found,
	input wire logic [COUNT_W-1:0]  count,
	input wire logic [COUNT_W-1:0]  free_slots,
	input wire logic [DATA_W-1:0]   first_value,
	input wire logic [DATA_W-1:0]   last_value
);

	localparam logic [COUNT_W-1:0] CAP_MOD = COUNT_W'(CAPACITY % 32);

	// A stalled result holds its status, count and end values.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
			&& $stable(first_value) && $stable(last_value))
		else $error("result changed while stalled");

	// While a result is valid, count and free slots add up to the capacity, modulo 32.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> COUNT_W'(count + free_slots) == CAP_MOD)
		else $error("count and free slots disagree with capacity");

	// An empty list reports zero end values.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count == '0 && CAPACITY < 32 |-> first_value == '0 && last_value == '0)
		else $error("empty list reported nonzero end values");

	// A found flag only comes with a good status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK)
		else $error("found flag with error status");

	// The engine works on one operation at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second operation taken while busy");

endmodule

bind sequential_list_engine_unit sle_checker #(
	.CAPACITY (CAPACITY)
) u_sle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.found       (rsp.found),
	.count       (rsp.count),
	.free_slots  (rsp.free_slots),
	.first_value (rsp.first_value),
	.last_value  (rsp.last_value)
);

`default_nettype wire
